// ----- hw/rtl/array_list_with_cursor_defines.svh -----
// Assertion macros used by the list top level.
`ifndef ARRAY_LIST_WITH_CURSOR_DEFINES_SVH
`define ARRAY_LIST_WITH_CURSOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALC_ASSERT_SAME(label, clock, reset_n, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ALC_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/alc_pkg.sv -----
package alc_pkg;

  localparam int OP_W       = 4;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 7;
  localparam int DATA_OUT_W = 32;
  localparam int IDX_OUT_W  = 6;
  localparam int LEN_OUT_W  = 7;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 4'd0,
    OP_APPEND = 4'd1,
    OP_REMOVE = 4'd2,
    OP_FIND   = 4'd3,
    OP_READ   = 4'd4,
    OP_SETPOS = 4'd5,
    OP_BEGIN  = 4'd6,
    OP_END    = 4'd7,
    OP_PREV   = 4'd8,
    OP_NEXT   = 4'd9,
    OP_CLEAR  = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_NO_CUR = 2'd2,
    STATUS_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ISSUE = 3'd1,
    ST_DRAIN = 3'd2,
    ST_PUT   = 3'd3,
    ST_FIN   = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic process;
    logic drain;
    logic put;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic has_cur;
    logic nonempty;
    logic last;
    logic hit;
  } dp_stat_t;

endpackage

// ----- hw/rtl/alc_ctrl.sv -----
module alc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [alc_pkg::OP_W-1:0]  in_op,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  alc_pkg::dp_stat_t         st,
  output alc_pkg::dp_cmd_t          cmd
);

  alc_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      alc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (alc_pkg::op_t'(in_op))
            alc_pkg::OP_INSERT: begin
              if (st.full) begin
                state_nxt = alc_pkg::ST_FIN;
              end else if (st.has_cur) begin
                state_nxt = alc_pkg::ST_ISSUE;
              end else begin
                state_nxt = alc_pkg::ST_PUT;
              end
            end
            alc_pkg::OP_REMOVE, alc_pkg::OP_READ: begin
              state_nxt = st.has_cur ? alc_pkg::ST_ISSUE : alc_pkg::ST_FIN;
            end
            alc_pkg::OP_FIND: begin
              state_nxt = st.nonempty ? alc_pkg::ST_ISSUE : alc_pkg::ST_FIN;
            end
            default: begin
              state_nxt = alc_pkg::ST_FIN;
            end
          endcase
        end
      end
      alc_pkg::ST_ISSUE: begin
        cmd.issue   = 1'b1;
        cmd.process = 1'b1;
        // A search stops at the first match; any read already in flight is dropped.
        if (st.hit) begin
          state_nxt = alc_pkg::ST_FIN;
        end else if (st.last) begin
          state_nxt = alc_pkg::ST_DRAIN;
        end
      end
      alc_pkg::ST_DRAIN: begin
        cmd.process = 1'b1;
        cmd.drain   = 1'b1;
        state_nxt   = (st.op == alc_pkg::OP_INSERT) ? alc_pkg::ST_PUT : alc_pkg::ST_FIN;
      end
      alc_pkg::ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = alc_pkg::ST_FIN;
      end
      alc_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = alc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = alc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != alc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/alc_dp.sv -----
module alc_dp #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  alc_pkg::dp_cmd_t                  cmd,
  output alc_pkg::dp_stat_t                 st,
  input  logic [alc_pkg::OP_W-1:0]          in_op,
  input  logic [alc_pkg::VALUE_W-1:0]       in_value,
  input  logic [alc_pkg::POS_W-1:0]         in_position,
  output logic [alc_pkg::DATA_OUT_W-1:0]    out_data_out,
  output logic [alc_pkg::IDX_OUT_W-1:0]     out_found_index,
  output logic [alc_pkg::LEN_OUT_W-1:0]     out_length_now,
  output logic [alc_pkg::LEN_OUT_W-1:0]     out_cursor_now,
  output logic [alc_pkg::STATUS_W-1:0]      out_status
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (LEN_W > alc_pkg::POS_W) ? LEN_W : alc_pkg::POS_W;

  logic [DATA_WIDTH-1:0] entries_r [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      cursor_r, cursor_nxt;
  alc_pkg::op_t          op_r, op_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [IDX_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  alc_pkg::status_t      status_r, status_nxt;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [alc_pkg::DATA_OUT_W-1:0] out_data_r;
  logic [alc_pkg::IDX_OUT_W-1:0]  out_idx_r;
  logic [alc_pkg::LEN_OUT_W-1:0]  out_len_r;
  logic [alc_pkg::LEN_OUT_W-1:0]  out_cursor_r;
  alc_pkg::status_t               out_status_r;

  logic match;

  assign match = (rdata_r == word_r);

  always_comb begin
    st.op       = op_r;
    st.full     = (len_r == LEN_W'(CAPACITY));
    st.has_cur  = (cursor_r < len_r);
    st.nonempty = (len_r != '0);
    st.hit      = rd_vld_r && (op_r == alc_pkg::OP_FIND) && match;
    case (op_r)
      alc_pkg::OP_INSERT: st.last = (ptr_r == IDX_W'(cursor_r));
      alc_pkg::OP_READ:   st.last = 1'b1;
      default:            st.last = (ptr_r == IDX_W'(len_r - 1'b1));
    endcase
  end

  always_comb begin
    len_nxt     = len_r;
    cursor_nxt  = cursor_r;
    op_nxt      = op_r;
    word_nxt    = word_r;
    ptr_nxt     = ptr_r;
    rd_addr_nxt = rd_addr_r;
    rd_vld_nxt  = cmd.issue;
    data_nxt    = data_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    mem_waddr   = ptr_r;
    mem_wdata   = word_r;

    if (cmd.load) begin
      op_nxt     = alc_pkg::op_t'(in_op);
      word_nxt   = DATA_WIDTH'(in_value);
      data_nxt   = '0;
      idx_nxt    = '0;
      status_nxt = alc_pkg::STATUS_OK;
      case (alc_pkg::op_t'(in_op))
        alc_pkg::OP_INSERT: begin
          if (st.full) begin
            status_nxt = alc_pkg::STATUS_FULL;
          end
          ptr_nxt = IDX_W'(len_r - 1'b1);
        end
        alc_pkg::OP_APPEND: begin
          if (st.full) begin
            status_nxt = alc_pkg::STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(len_r);
            mem_wdata = DATA_WIDTH'(in_value);
            len_nxt   = len_r + 1'b1;
          end
        end
        alc_pkg::OP_REMOVE, alc_pkg::OP_READ: begin
          if (!st.has_cur) begin
            status_nxt = alc_pkg::STATUS_NO_CUR;
          end
          ptr_nxt = IDX_W'(cursor_r);
        end
        alc_pkg::OP_FIND: begin
          // Not found until the scan proves otherwise.
          cursor_nxt = '0;
          status_nxt = alc_pkg::STATUS_RANGE;
          ptr_nxt    = '0;
        end
        alc_pkg::OP_SETPOS: begin
          if (CMP_W'(in_position) > CMP_W'(len_r)) begin
            status_nxt = alc_pkg::STATUS_RANGE;
          end else begin
            cursor_nxt = LEN_W'(in_position);
          end
        end
        alc_pkg::OP_BEGIN: cursor_nxt = '0;
        alc_pkg::OP_END:   cursor_nxt = len_r;
        alc_pkg::OP_PREV: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - 1'b1;
          end
        end
        alc_pkg::OP_NEXT: begin
          if (st.has_cur) begin
            cursor_nxt = cursor_r + 1'b1;
          end
        end
        alc_pkg::OP_CLEAR: begin
          len_nxt    = '0;
          cursor_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.issue) begin
      rd_addr_nxt = ptr_r;
      ptr_nxt     = (op_r == alc_pkg::OP_INSERT) ? ptr_r - 1'b1 : ptr_r + 1'b1;
    end

    // Insert walks downward and moves each word up one slot; remove walks
    // upward and moves each word down one slot, capturing the word at the cursor as the result.
    if (cmd.process && rd_vld_r) begin
      case (op_r)
        alc_pkg::OP_INSERT: begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_r + 1'b1;
          mem_wdata = rdata_r;
        end
        alc_pkg::OP_REMOVE: begin
          if (rd_addr_r == IDX_W'(cursor_r)) begin
            data_nxt = rdata_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_r - 1'b1;
            mem_wdata = rdata_r;
          end
        end
        alc_pkg::OP_FIND: begin
          if (match) begin
            idx_nxt    = rd_addr_r;
            status_nxt = alc_pkg::STATUS_OK;
          end
        end
        alc_pkg::OP_READ: data_nxt = rdata_r;
        default: begin
        end
      endcase
    end

    if (cmd.drain && (op_r == alc_pkg::OP_REMOVE)) begin
      len_nxt = len_r - 1'b1;
    end

    if (cmd.put) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(cursor_r);
      mem_wdata = word_r;
      len_nxt   = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      cursor_r <= '0;
      op_r     <= alc_pkg::OP_INSERT;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      cursor_r <= cursor_nxt;
      op_r     <= op_nxt;
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    rd_addr_r <= rd_addr_nxt;
    data_r    <= data_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_r[mem_waddr] <= mem_wdata;
    end
    if (cmd.issue) begin
      rdata_r <= entries_r[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r   <= alc_pkg::DATA_OUT_W'(data_r);
      out_idx_r    <= alc_pkg::IDX_OUT_W'(idx_r);
      out_len_r    <= alc_pkg::LEN_OUT_W'(len_r);
      out_cursor_r <= alc_pkg::LEN_OUT_W'(cursor_r);
      out_status_r <= status_r;
    end
  end

  assign out_data_out    = out_data_r;
  assign out_found_index = out_idx_r;
  assign out_length_now  = out_len_r;
  assign out_cursor_now  = out_cursor_r;
  assign out_status      = out_status_r;

endmodule

// ----- hw/rtl/array_list_with_cursor.sv -----
// Append, cursor moves, clear and rejected operations go straight to the result; read takes the
// word at the cursor; remove scans from the cursor to the end, moving words down; find scans from
// the start and stops at the first match; insert scans from the end down to the cursor, moving words
// up, then writes the new word (at once with the cursor at the end). One item at a time: the input
// stays stalled until the result registers, after any output stall; memory does one read and one write a cycle.
// Synchronous active-low reset empties the list (length and cursor zero); stored words are kept.
`include "array_list_with_cursor_defines.svh"

module array_list_with_cursor #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [alc_pkg::OP_W-1:0]          in_op,
  input  logic [alc_pkg::VALUE_W-1:0]       in_value,
  input  logic [alc_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [alc_pkg::DATA_OUT_W-1:0]    out_data_out,
  output logic [alc_pkg::IDX_OUT_W-1:0]     out_found_index,
  output logic [alc_pkg::LEN_OUT_W-1:0]     out_length_now,
  output logic [alc_pkg::LEN_OUT_W-1:0]     out_cursor_now,
  output logic [alc_pkg::STATUS_W-1:0]      out_status
);

  alc_pkg::dp_cmd_t  cmd;
  alc_pkg::dp_stat_t st;

  alc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  alc_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_data_out    (out_data_out),
    .out_found_index (out_found_index),
    .out_length_now  (out_length_now),
    .out_cursor_now  (out_cursor_now),
    .out_status      (out_status)
  );

  // An accepted item keeps the input stalled in the cycle after its transfer.
  `ALC_ASSERT_NEXT(a_accept_blocks_next, clk, rst_n, in_valid && !in_stall, in_stall)
  // Rejected or failed operations never return a word.
  `ALC_ASSERT_SAME(a_error_no_data, clk, rst_n, out_valid && (out_status != alc_pkg::STATUS_OK), out_data_out == '0)
  // No current element means the cursor sits at the end of the list.
  `ALC_ASSERT_SAME(a_no_cur_at_end, clk, rst_n, out_valid && (out_status == alc_pkg::STATUS_NO_CUR), out_cursor_now == out_length_now)

endmodule
